// ===== rtl/bffsc_pkg.sv =====
// Package for the bitmap find-first-set/clear core.
// Holds operation codes, field widths and the structs shared by the core's modules.
// No dependencies.
package bffsc_pkg;

  localparam int unsigned WORD_BITS       = 64;
  localparam int unsigned OFS_W           = 6;
  localparam int unsigned POS_W           = 12;
  localparam int unsigned CNT_W           = 13;
  localparam int unsigned SCAN_W          = 7;
  localparam int unsigned INDEX_LIMIT     = 4096;
  localparam int unsigned BIT_COUNT_RESET = 4096;
  localparam logic        REG_BIT_COUNT   = 1'b0;

  typedef enum logic [2:0] {
    OP_READ        = 3'd0,
    OP_WRITE       = 3'd1,
    OP_FLIP        = 3'd2,
    OP_COPY        = 3'd3,
    OP_FIRST_SET   = 3'd4,
    OP_FIRST_CLEAR = 3'd5,
    OP_IS_ZERO     = 3'd6
  } op_e;

  typedef struct packed {
    logic [OFS_W-1:0] ofs;
    logic             val;
    logic             flip;
    logic             inv;
  } wu_ctl_t;

  typedef struct packed {
    logic             old_bit;
    logic             new_bit;
    logic             nonzero;
    logic [OFS_W-1:0] tz;
  } wu_res_t;

  typedef struct packed {
    logic             index_error;
    logic             all_zero;
    logic             found;
    logic [POS_W-1:0] position;
    logic             bit_value;
  } res_t;

endpackage

// ===== rtl/bffsc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Standalone; used for the bitmap word store.
module bffsc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bffsc_word_unit.sv =====
// Shared word unit: bit pick, bit update and trailing-zero count on one 64-bit word.
// Depends on bffsc_pkg.
module bffsc_word_unit (
  input  logic [63:0]       word_i,
  input  bffsc_pkg::wu_ctl_t ctl_i,
  output logic [63:0]       word_o,
  output bffsc_pkg::wu_res_t res_o
);
  import bffsc_pkg::*;

  function automatic logic [OFS_W-1:0] tzc(input logic [WORD_BITS-1:0] w);
    logic [OFS_W-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) n = OFS_W'(i);
    end
    return n;
  endfunction

  logic [WORD_BITS-1:0] scan_word;
  logic                 nb;

  assign scan_word = ctl_i.inv ? ~word_i : word_i;
  assign nb        = ctl_i.flip ? ~word_i[ctl_i.ofs] : ctl_i.val;

  always_comb begin
    word_o            = word_i;
    word_o[ctl_i.ofs] = nb;
  end

  assign res_o.old_bit = word_i[ctl_i.ofs];
  assign res_o.new_bit = nb;
  assign res_o.nonzero = |scan_word;
  assign res_o.tz      = tzc(scan_word);

endmodule

// ===== rtl/bitmap_find_first_set_clear_core.sv =====
// Bitmap find-first-set/clear core: a map of WORDS 64-bit words in one RAM,
// zeroed after reset by a clearing pass over all WORDS words during which no
// transaction is taken (configuration writes still are). Bit read, write and
// flip finish in the read state, copy reads the source bit first, errors and
// unused codes finish from idle; first set, first clear and is zero scan at
// most 64 words, since the single RAM read port delivers one word per cycle to
// the shared word unit. Depends on bffsc_pkg, bffsc_ram and bffsc_word_unit.
module bitmap_find_first_set_clear_core #(
  parameter int unsigned WORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,  // bit_index[11:0], source_index[23:12], write_value[24]
  input  logic [2:0]  s_tuser_i,  // op[2:0]
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o   // bit_value[0], position[12:1], found[13],
                                  // all_zero[14], index_error[15]
);
  import bffsc_pkg::*;

  localparam int unsigned ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned MAP_BITS  = WORDS * WORD_BITS;
  localparam int unsigned LIMIT_INT = (MAP_BITS < INDEX_LIMIT) ? MAP_BITS : INDEX_LIMIT;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_INT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CPS   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [POS_W-1:0]    bi_q, bi_d;
  logic [OFS_W-1:0]    si_q, si_d;
  logic                val_q, val_d;
  logic [SCAN_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]    bit_count_q;
  res_t                res_q, res_d, res, out_q, out_d;
  logic                m_valid_q, m_valid_d;
  logic                fin, out_load, out_free;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [63:0]         ram_wdata, ram_rdata, new_word;
  wu_ctl_t             wu_ctl;
  wu_res_t             wu_res;

  logic [CNT_W-1:0]    count_eff;
  logic [SCAN_W-1:0]   nw;
  op_e                 in_op;
  logic [POS_W-1:0]    in_bi, in_si;
  logic                in_wv, bi_err, si_err;
  logic [OFS_W-1:0]    scan_idx;
  logic [POS_W-1:0]    scan_pos;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BIT_COUNT) ? 32'(bit_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= CNT_W'(BIT_COUNT_RESET);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BIT_COUNT) begin
      bit_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign count_eff = (bit_count_q > LIMIT) ? LIMIT : bit_count_q;
  assign nw        = SCAN_W'((14'(count_eff) + 14'd63) >> 6);

  assign in_op  = op_e'(s_tuser_i);
  assign in_bi  = s_tdata_i[11:0];
  assign in_si  = s_tdata_i[23:12];
  assign in_wv  = s_tdata_i[24];
  assign bi_err = CNT_W'(in_bi) >= count_eff;
  assign si_err = CNT_W'(in_si) >= count_eff;

  assign scan_idx = OFS_W'(cnt_q - SCAN_W'(1));
  assign scan_pos = {scan_idx, wu_res.tz};

  bffsc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign wu_ctl.ofs  = (state_q == ST_CPS) ? si_q : bi_q[OFS_W-1:0];
  assign wu_ctl.val  = val_q;
  assign wu_ctl.flip = (op_q == OP_FLIP);
  assign wu_ctl.inv  = (op_q == OP_FIRST_CLEAR);

  bffsc_word_unit u_word_unit (
    .word_i (ram_rdata),
    .ctl_i  (wu_ctl),
    .word_o (new_word),
    .res_o  (wu_res)
  );

  assign out_free = !m_valid_q || m_tready_i;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    bi_d       = bi_q;
    si_d       = si_q;
    val_d      = val_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    res_d      = res_q;
    res        = '0;
    fin        = 1'b0;
    out_load   = 1'b0;
    out_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = ADDR_W'(bi_q[POS_W-1:OFS_W]);
    ram_wdata  = new_word;
    ram_raddr  = '0;
    s_tready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          op_d  = in_op;
          bi_d  = in_bi;
          si_d  = in_si[OFS_W-1:0];
          val_d = in_wv;
          case (in_op)
            OP_READ, OP_WRITE, OP_FLIP: begin
              if (bi_err) begin
                fin               = 1'b1;
                res.index_error   = 1'b1;
              end else begin
                ram_raddr = ADDR_W'(in_bi[POS_W-1:OFS_W]);
                state_d   = ST_RD;
              end
            end
            OP_COPY: begin
              if (bi_err || si_err) begin
                fin             = 1'b1;
                res.index_error = 1'b1;
              end else begin
                ram_raddr = ADDR_W'(in_si[POS_W-1:OFS_W]);
                state_d   = ST_CPS;
              end
            end
            OP_FIRST_SET, OP_FIRST_CLEAR, OP_IS_ZERO: begin
              if (nw == '0) begin
                fin          = 1'b1;
                res.all_zero = (in_op == OP_IS_ZERO);
              end else begin
                ram_raddr = '0;
                cnt_d     = SCAN_W'(1);
                state_d   = ST_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_CPS: begin
        val_d     = wu_res.old_bit;
        ram_raddr = ADDR_W'(bi_q[POS_W-1:OFS_W]);
        state_d   = ST_RD;
      end
      ST_RD: begin
        ram_we        = (op_q != OP_READ);
        res.bit_value = (op_q == OP_READ) ? wu_res.old_bit : wu_res.new_bit;
        fin           = 1'b1;
      end
      ST_SCAN: begin
        if (wu_res.nonzero) begin
          fin = 1'b1;
          if (op_q != OP_IS_ZERO && CNT_W'(scan_pos) < count_eff) begin
            res.found    = 1'b1;
            res.position = scan_pos;
          end
        end else if (cnt_q == nw) begin
          fin          = 1'b1;
          res.all_zero = (op_q == OP_IS_ZERO);
        end else begin
          ram_raddr = ADDR_W'(cnt_q[OFS_W-1:0]);
          cnt_d     = cnt_q + SCAN_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = res_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        out_d    = res;
        state_d  = ST_IDLE;
      end else begin
        res_d   = res;
        state_d = ST_HOLD;
      end
    end
  end

  assign m_valid_d = out_load || (m_valid_q && !m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    bi_q  <= bi_d;
    si_q  <= si_d;
    val_q <= val_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = out_q;

endmodule
